// ----- hdl/active_expired_priority_run_queue_assert.svh -----
// assertion macros for the run queue
`ifndef ACTIVE_EXPIRED_PRIORITY_RUN_QUEUE_ASSERT_SVH
`define ACTIVE_EXPIRED_PRIORITY_RUN_QUEUE_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define AEPQ_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("run queue check failed");

// next-cycle implication, sampled on clk, off during reset
`define AEPQ_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("run queue check failed");

`endif

// ----- hdl/aepq_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package aepq_pkg;

    typedef enum logic [2:0] {
        ST_ADDED     = 3'd0,
        ST_GRANTED   = 3'd1,
        ST_EMPTY     = 3'd2,
        ST_FULL      = 3'd3,
        ST_BAD_LEVEL = 3'd4
    } status_t;

    localparam logic       MODE_ADD    = 1'b0;
    localparam logic       MODE_GET    = 1'b1;
    localparam logic [3:0] DYN_EXPIRED = 4'hF;
    localparam logic [2:0] TOP_RESET   = 3'd4;

endpackage

`default_nettype wire

// ----- hdl/active_expired_priority_run_queue.sv -----
// latency: the result strobe (done) comes in the cycle right after the transaction is accepted
// throughput: one transaction per cycle, busy stays low; set by the single registered pass
//   through the per-fifo head/count flops and one write or one read of the queue memory
// results cannot be stalled by the receiver
// reset: all fifos empty, bank 0 active, top_level 4; the queue memory is not cleared
`timescale 1ns / 1ps
`default_nettype none
`include "active_expired_priority_run_queue_assert.svh"

module active_expired_priority_run_queue #(
    parameter int LEVELS     = 8,
    parameter int FIFO_DEPTH = 16,
    parameter int ID_WIDTH   = 8
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic                   cfg_we,
    input  logic [2:0]             cfg_wdata,
    input  logic                   mode,
    input  logic [7:0]             task_id,
    input  logic signed [3:0]      dyn_prio,
    input  logic [3:0]             static_prio,
    output logic                   done,
    output aepq_pkg::status_t      status,
    output logic [7:0]             out_task,
    output logic [2:0]             out_level,
    output logic                   to_expired,
    output logic                   banks_swapped
);

    import aepq_pkg::*;

    localparam int NFIFO = 2 * LEVELS;
    localparam int DEPTH = NFIFO * FIFO_DEPTH;
    localparam int AW    = $clog2(DEPTH);
    localparam int FW    = $clog2(NFIFO);
    localparam int LW    = $clog2(LEVELS);
    localparam int HW    = $clog2(FIFO_DEPTH);
    localparam int CW    = $clog2(FIFO_DEPTH + 1);
    localparam int SW    = HW + 1;
    localparam int LXW   = (LW > 3) ? LW : 3;
    localparam int IXW   = (ID_WIDTH > 8) ? ID_WIDTH : 8;
    localparam int SCAN  = (LEVELS < 8) ? LEVELS : 8;

    logic [CW-1:0] cnt_reg  [NFIFO];
    logic [CW-1:0] cnt_next [NFIFO];
    logic [HW-1:0] head_reg [NFIFO];
    logic [HW-1:0] head_next[NFIFO];
    logic          bank_reg, bank_next;
    logic [2:0]    top_level_reg;
    logic          done_reg;

    status_t       status_reg, status_next;
    logic [2:0]    level_reg, level_next;
    logic          exp_reg, exp_next;
    logic          swap_reg, swap_next;
    logic          grant_reg, grant_next;

    logic          accept;
    logic [2:0]    top_eff;

    logic          add_exp, add_bad, add_full, add_bank;
    logic [3:0]    add_lvl4;
    logic [LXW-1:0] add_lvl_ext;
    logic [LW-1:0] add_lvl;
    logic [FW-1:0] add_f;
    logic [SW-1:0] slot_sum;
    logic [SW-1:0] slot_wrap;
    logic [IXW-1:0] id_ext;

    logic [SCAN-1:0] act_nz, exp_nz, pick;
    logic          get_swap, get_bank, get_found;
    logic [2:0]    get_lvl3;
    logic [LXW-1:0] get_lvl_ext;
    logic [LW-1:0] get_lvl;
    logic [FW-1:0] get_f;
    logic [HW-1:0] get_head, head_inc;

    logic          ram_we, ram_re;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [ID_WIDTH-1:0] ram_wdata, ram_rdata;
    logic [IXW-1:0] rd_ext;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_comb
    begin
        if ({3'b000, top_level_reg} > 6'(LEVELS - 1))
        begin
            top_eff = 3'(LEVELS - 1);
        end
        else
        begin
            top_eff = top_level_reg;
        end
    end

    // add path
    always_comb
    begin
        add_exp = ($unsigned(dyn_prio) == DYN_EXPIRED);
        if (add_exp)
        begin
            add_lvl4 = static_prio - 4'd1;
            add_bad  = (static_prio == 4'd0) || (add_lvl4 > {1'b0, top_eff});
        end
        else
        begin
            add_lvl4 = $unsigned(dyn_prio);
            add_bad  = dyn_prio[3] || (add_lvl4 > {1'b0, top_eff});
        end
        add_bank    = bank_reg ^ add_exp;
        add_lvl_ext = LXW'(add_lvl4[2:0]);
        add_lvl     = add_lvl_ext[LW-1:0];
        add_f       = FW'(add_bank) * FW'(LEVELS) + FW'(add_lvl);
        add_full    = (cnt_reg[add_f] >= CW'(FIFO_DEPTH));
        slot_sum    = SW'(head_reg[add_f]) + SW'(cnt_reg[add_f]);
        if (slot_sum >= SW'(FIFO_DEPTH))
        begin
            slot_wrap = slot_sum - SW'(FIFO_DEPTH);
        end
        else
        begin
            slot_wrap = slot_sum;
        end
        ram_waddr = AW'(add_f) * AW'(FIFO_DEPTH) + AW'(slot_wrap[HW-1:0]);
        id_ext    = IXW'(task_id);
        ram_wdata = id_ext[ID_WIDTH-1:0];
    end

    // get path
    always_comb
    begin
        for (int j = 0; j < SCAN; j++)
        begin
            act_nz[j] = (cnt_reg[FW'(bank_reg) * FW'(LEVELS) + FW'(j)] != '0)
                        && (3'(j) <= top_eff);
            exp_nz[j] = (cnt_reg[FW'(!bank_reg) * FW'(LEVELS) + FW'(j)] != '0)
                        && (3'(j) <= top_eff);
        end
        get_swap  = !(|act_nz);
        get_bank  = bank_reg ^ get_swap;
        pick      = get_swap ? exp_nz : act_nz;
        get_found = |pick;
        get_lvl3  = 3'd0;
        for (int j = 0; j < SCAN; j++)
        begin
            if (pick[j])
            begin
                get_lvl3 = 3'(j);
            end
        end
        get_lvl_ext = LXW'(get_lvl3);
        get_lvl     = get_lvl_ext[LW-1:0];
        get_f       = FW'(get_bank) * FW'(LEVELS) + FW'(get_lvl);
        get_head    = head_reg[get_f];
        head_inc    = (get_head == HW'(FIFO_DEPTH - 1)) ? '0 : get_head + HW'(1);
        ram_raddr   = AW'(get_f) * AW'(FIFO_DEPTH) + AW'(get_head);
    end

    // state and result updates
    always_comb
    begin
        cnt_next    = cnt_reg;
        head_next   = head_reg;
        bank_next   = bank_reg;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        status_next = ST_ADDED;
        level_next  = 3'd0;
        exp_next    = 1'b0;
        swap_next   = 1'b0;
        grant_next  = 1'b0;
        if (mode == MODE_ADD)
        begin
            if (add_bad)
            begin
                status_next = ST_BAD_LEVEL;
            end
            else
            begin
                level_next = add_lvl4[2:0];
                exp_next   = add_exp;
                if (add_full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    status_next = ST_ADDED;
                    ram_we      = accept;
                    if (accept)
                    begin
                        cnt_next[add_f] = cnt_reg[add_f] + CW'(1);
                    end
                end
            end
        end
        else
        begin
            swap_next   = get_swap;
            status_next = ST_EMPTY;
            if (accept)
            begin
                bank_next = get_bank;
            end
            if (get_found)
            begin
                status_next = ST_GRANTED;
                level_next  = get_lvl3;
                grant_next  = 1'b1;
                ram_re      = accept;
                if (accept)
                begin
                    cnt_next[get_f]  = cnt_reg[get_f] - CW'(1);
                    head_next[get_f] = head_inc;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NFIFO; i++)
            begin
                cnt_reg[i]  <= '0;
                head_reg[i] <= '0;
            end
            bank_reg      <= 1'b0;
            top_level_reg <= TOP_RESET;
            done_reg      <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            head_reg <= head_next;
            bank_reg <= bank_next;
            done_reg <= accept;
            if (cfg_we)
            begin
                top_level_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg <= status_next;
            level_reg  <= level_next;
            exp_reg    <= exp_next;
            swap_reg   <= swap_next;
            grant_reg  <= grant_next;
        end
    end

    aepq_ram #(
        .WIDTH (ID_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_ext        = IXW'(ram_rdata);
    assign done          = done_reg;
    assign status        = status_reg;
    assign out_task      = grant_reg ? rd_ext[7:0] : 8'd0;
    assign out_level     = level_reg;
    assign to_expired    = exp_reg;
    assign banks_swapped = swap_reg;

    `AEPQ_ASSERT_NEXT(a_result_follows, start && !busy, done)
    `AEPQ_ASSERT_NOW(a_bank_flip_reported, bank_reg != $past(bank_reg), done_reg && swap_reg)
    `AEPQ_ASSERT_NOW(a_swap_on_get_only, done_reg && swap_reg,
        status_reg == ST_GRANTED || status_reg == ST_EMPTY)
    `AEPQ_ASSERT_NOW(a_bad_level_clean, done_reg && status_reg == ST_BAD_LEVEL,
        level_reg == 3'd0 && !exp_reg && !swap_reg)
    `AEPQ_ASSERT_NOW(a_expired_on_add, done_reg && exp_reg,
        status_reg == ST_ADDED || status_reg == ST_FULL)

endmodule

`default_nettype wire

// ----- hdl/aepq_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module aepq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- test/active_expired_priority_run_queue_tb.sv -----
`timescale 1ns / 1ps

module active_expired_priority_run_queue_tb;

    import aepq_pkg::*;

    localparam int LEVEL_COUNT   = 8;
    localparam int FIFO_SLOTS    = 16;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int PENDING_SLOTS = 64;

    typedef struct {
        status_t  status;
        bit [7:0] granted;
        bit [2:0] level;
        bit       expired;
        bit       swapped;
    } sched_result_t;

    logic             clk;
    logic             rst_n;
    logic             start;
    logic             busy;
    logic             cfg_we;
    logic [2:0]       cfg_wdata;
    logic             mode;
    logic [7:0]       task_id;
    logic [3:0]       dyn_prio;
    logic [3:0]       static_prio;
    logic             done;
    status_t          status;
    logic [7:0]       out_task;
    logic [2:0]       out_level;
    logic             to_expired;
    logic             banks_swapped;

    // shadow copy of the run queue
    bit [7:0]         task_ring [2][LEVEL_COUNT][FIFO_SLOTS];
    bit [3:0]         fifo_front [2][LEVEL_COUNT];
    bit [4:0]         fifo_fill [2][LEVEL_COUNT];
    bit               active_bank;
    bit [2:0]         run_top;

    // expected results, in order of acceptance
    sched_result_t    expected_results [PENDING_SLOTS];
    int               pending_head;
    int               pending_tail;
    int               errors;
    int               cycles;
    bit               gaps_on;

    active_expired_priority_run_queue dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .mode          (mode),
        .task_id       (task_id),
        .dyn_prio      (dyn_prio),
        .static_prio   (static_prio),
        .done          (done),
        .status        (status),
        .out_task      (out_task),
        .out_level     (out_level),
        .to_expired    (to_expired),
        .banks_swapped (banks_swapped)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic int pending_count();
        return pending_tail - pending_head;
    endfunction

    function automatic sched_result_t predict_request(bit m, bit [7:0] id,
                                                      bit [3:0] dyn_raw, bit [3:0] stat);
        sched_result_t r;
        int            lvl;
        int            slot;
        int            j;
        bit            bk;
        bit            exp_bank;
        bit            any_ready;
        bit            found;
        r.status  = ST_ADDED;
        r.granted = '0;
        r.level   = '0;
        r.expired = 1'b0;
        r.swapped = 1'b0;
        if (m == MODE_ADD)
        begin
            bk       = active_bank;
            exp_bank = 1'b0;
            if (dyn_raw == DYN_EXPIRED)
            begin
                lvl      = int'(stat) - 1;
                exp_bank = 1'b1;
                bk       = ~bk;
            end
            else
            begin
                lvl = int'($signed(dyn_raw));
            end
            if (lvl < 0 || lvl > int'(run_top))
            begin
                r.status = ST_BAD_LEVEL;
            end
            else
            begin
                r.level   = 3'(lvl);
                r.expired = exp_bank;
                if (fifo_fill[bk][lvl] >= FIFO_SLOTS)
                begin
                    r.status = ST_FULL;
                end
                else
                begin
                    slot = (int'(fifo_front[bk][lvl]) + int'(fifo_fill[bk][lvl])) % FIFO_SLOTS;
                    task_ring[bk][lvl][slot] = id;
                    fifo_fill[bk][lvl]++;
                end
            end
        end
        else
        begin
            any_ready = 1'b0;
            for (j = 0; j <= int'(run_top); j++)
            begin
                if (fifo_fill[active_bank][j] != 0)
                    any_ready = 1'b1;
            end
            if (!any_ready)
            begin
                active_bank = ~active_bank;
                r.swapped   = 1'b1;
            end
            r.status = ST_EMPTY;
            found    = 1'b0;
            for (j = int'(run_top); j >= 0; j--)
            begin
                if (!found && fifo_fill[active_bank][j] != 0)
                begin
                    r.granted = task_ring[active_bank][j][fifo_front[active_bank][j]];
                    fifo_front[active_bank][j]++;
                    fifo_fill[active_bank][j]--;
                    r.level  = 3'(j);
                    r.status = ST_GRANTED;
                    found    = 1'b1;
                end
            end
        end
        return r;
    endfunction

    task automatic check_field(string name, int want, int got);
        if (want != got)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
        end
    endtask

    // result checker
    always @(posedge clk)
    begin
        sched_result_t want;
        if (rst_n && done)
        begin
            if (pending_count() == 0)
            begin
                errors++;
                $display("%0t: unexpected result, expected none actual status %0d",
                         $time, int'(status));
            end
            else
            begin
                want = expected_results[pending_head % PENDING_SLOTS];
                pending_head++;
                check_field("status", int'(want.status), int'(status));
                check_field("out_task", int'(want.granted), int'(out_task));
                check_field("out_level", int'(want.level), int'(out_level));
                check_field("to_expired", int'(want.expired), int'(to_expired));
                check_field("banks_swapped", int'(want.swapped), int'(banks_swapped));
            end
        end
    end

    task automatic send_request(bit m, bit [7:0] id, bit [3:0] dyn_raw, bit [3:0] stat);
        @(negedge clk);
        start       <= 1'b1;
        mode        <= m;
        task_id     <= id;
        dyn_prio    <= dyn_raw;
        static_prio <= stat;
        forever
        begin
            @(posedge clk);
            if (!busy)
                break;
        end
        expected_results[pending_tail % PENDING_SLOTS] = predict_request(m, id, dyn_raw, stat);
        pending_tail++;
    endtask

    task automatic idle_gap();
        int pick;
        int n;
        pick = $urandom_range(0, 99);
        n    = 0;
        if (gaps_on)
        begin
            if (pick >= 95)
                n = $urandom_range(8, 40);
            else if (pick >= 55)
                n = $urandom_range(1, 3);
        end
        if (n > 0)
        begin
            @(negedge clk);
            start <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic wait_idle();
        @(negedge clk);
        start <= 1'b0;
        while (pending_count() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_top(bit [2:0] value);
        wait_idle();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        run_top = value;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic send_add(bit [7:0] id, bit [3:0] dyn_raw, bit [3:0] stat);
        send_request(MODE_ADD, id, dyn_raw, stat);
        idle_gap();
    endtask

    task automatic send_get();
        send_request(MODE_GET, 8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)),
                     4'($urandom_range(0, 15)));
        idle_gap();
    endtask

    task automatic send_random(int get_pct);
        bit [7:0] id;
        bit [3:0] d;
        bit [3:0] s;
        id = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 99) < 10)
        begin
            // noise: any field values
            d = 4'($urandom_range(0, 15));
            s = 4'($urandom_range(0, 15));
            send_request(1'($urandom_range(0, 1)), id, d, s);
            idle_gap();
        end
        else if ($urandom_range(0, 99) < get_pct)
        begin
            send_get();
        end
        else if ($urandom_range(0, 99) < 25)
        begin
            send_add(id, DYN_EXPIRED, 4'($urandom_range(1, int'(run_top) + 1)));
        end
        else
        begin
            send_add(id, 4'($urandom_range(0, int'(run_top))),
                     4'($urandom_range(0, 15)));
        end
    endtask

    task automatic test_directed();
        gaps_on = 1'b0;
        send_get();
        send_add(8'h00, 4'd0, 4'd1);
        send_add(8'hFF, 4'd4, 4'd8);
        send_add(8'h11, 4'd5, 4'd1);
        send_add(8'h12, 4'd7, 4'd0);
        send_add(8'h21, DYN_EXPIRED, 4'd1);
        send_add(8'h22, DYN_EXPIRED, 4'd5);
        send_add(8'h23, DYN_EXPIRED, 4'd8);
        send_add(8'h24, DYN_EXPIRED, 4'd0);
        send_add(8'h25, DYN_EXPIRED, 4'd15);
        send_add(8'h26, 4'h8, 4'd3);
        send_add(8'h27, 4'hE, 4'd3);
        send_get();
        send_get();
        send_get();
        send_get();
        send_get();
        write_top(3'd7);
        send_add(8'hA5, 4'd7, 4'd2);
        send_add(8'h5A, DYN_EXPIRED, 4'd8);
        send_add(8'h3C, 4'd6, 4'd2);
        send_get();
        write_top(3'd0);
        send_add(8'h01, 4'd1, 4'd1);
        send_add(8'h02, 4'd0, 4'd1);
        // levels above the top stay parked
        send_get();
        send_get();
    endtask

    task automatic test_fifo_full();
        bit [3:0] lvl;
        int       round;
        gaps_on = 1'b1;
        write_top(3'd7);
        for (round = 0; round < 4; round++)
        begin
            lvl = 4'($urandom_range(0, 7));
            repeat (20)
            begin
                if (round[0])
                    send_add(8'($urandom_range(0, 255)), DYN_EXPIRED, lvl + 4'd1);
                else
                    send_add(8'($urandom_range(0, 255)), lvl, 4'($urandom_range(0, 15)));
            end
            repeat (6) send_get();
        end
    endtask

    task automatic test_random_traffic();
        int phase;
        int n;
        int get_pct;
        for (phase = 0; phase < 8; phase++)
        begin
            case (phase)
                0:       write_top(3'd7);
                1:       write_top(3'd0);
                2:       write_top(3'd3);
                3:       write_top(3'd7);
                default: write_top(3'($urandom_range(0, 7)));
            endcase
            gaps_on = (phase != 2) && (phase != 5);
            get_pct = (phase % 3 == 0) ? 30 : ((phase % 3 == 1) ? 45 : 60);
            for (n = 0; n < 120; n++)
            begin
                send_random(get_pct);
                if (n == 60)
                    wait_idle();
            end
        end
    endtask

    initial
    begin
        int n;
        rst_n        = 1'b0;
        start        = 1'b0;
        cfg_we       = 1'b0;
        cfg_wdata    = '0;
        mode         = MODE_ADD;
        task_id      = '0;
        dyn_prio     = '0;
        static_prio  = '0;
        errors       = 0;
        cycles       = 0;
        pending_head = 0;
        pending_tail = 0;
        gaps_on      = 1'b0;
        active_bank  = 1'b0;
        run_top      = TOP_RESET;
        for (int b = 0; b < 2; b++)
        begin
            for (int l = 0; l < LEVEL_COUNT; l++)
            begin
                fifo_front[b][l] = '0;
                fifo_fill[b][l]  = '0;
            end
        end
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_fifo_full();
        test_random_traffic();

        @(negedge clk);
        start <= 1'b0;
        for (n = 0; n < 200 && pending_count() != 0; n++)
            @(posedge clk);
        repeat (4) @(posedge clk);
        if (pending_count() != 0)
        begin
            errors++;
            $display("%0t: results missing, expected %0d actual 0",
                     $time, pending_count());
        end
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
